/* hw/rtl/cal_pkg.sv */
// Shared types, constants and calendar helper functions for the calendar date counter.
// Has no dependencies; every other file in hw/rtl refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package cal_pkg;

	// Operation codes carried in the input tuser field.
	typedef enum logic [2:0] {
		OP_NEXT     = 3'd0,
		OP_PREV     = 3'd1,
		OP_ADD      = 3'd2,
		OP_SUB      = 3'd3,
		OP_SET      = 3'd4,
		OP_COMPARE  = 3'd5
	} cal_op_t;

	// Width of a year taken modulo 400.
	localparam int unsigned REM_W = 9;

	localparam logic [REM_W-1:0] YEAR_CYCLE     = 9'd400;
	localparam logic [REM_W-1:0] REM_LAST       = 9'd399;
	localparam logic [REM_W-1:0] CENTURY_1      = 9'd100;
	localparam logic [REM_W-1:0] CENTURY_2      = 9'd200;
	localparam logic [REM_W-1:0] CENTURY_3      = 9'd300;
	localparam logic [4:0]       DAYS_FEB       = 5'd28;
	localparam logic [4:0]       DAYS_FEB_LEAP  = 5'd29;
	localparam logic [4:0]       DAYS_SHORT     = 5'd30;
	localparam logic [4:0]       DAYS_LONG      = 5'd31;
	localparam logic [3:0]       MONTH_FEB      = 4'd2;
	localparam logic [3:0]       MONTH_APR      = 4'd4;
	localparam logic [3:0]       MONTH_JUN      = 4'd6;
	localparam logic [3:0]       MONTH_SEP      = 4'd9;
	localparam logic [3:0]       MONTH_NOV      = 4'd11;
	localparam logic [3:0]       MONTH_DEC      = 4'd12;
	localparam logic [3:0]       MONTH_JAN      = 4'd1;
	localparam logic [4:0]       DAY_FIRST      = 5'd1;

	// The date after reset is 1 January 2000; 2000 is a multiple of 400.
	localparam logic [4:0]       RESET_DAY      = 5'd1;
	localparam logic [3:0]       RESET_MONTH    = 4'd1;
	localparam int unsigned      RESET_YEAR     = 2000;
	localparam logic [REM_W-1:0] RESET_REM      = 9'd0;

	// Day and month of the stored date, plus the year modulo 400.
	typedef struct packed {
		logic [4:0]       day;
		logic [3:0]       month;
		logic [REM_W-1:0] rem;
	} cal_date_t;

	// Status of the iterative modulo-400 unit.
	typedef struct packed {
		logic             busy;
		logic [REM_W-1:0] rem;
	} cal_mod_stat_t;

	// Leap year test from the year modulo 400.
	function automatic logic cal_leap(input logic [REM_W-1:0] rem);
		logic cent;
		cent = (rem == CENTURY_1) || (rem == CENTURY_2) || (rem == CENTURY_3);
		return (rem[1:0] == 2'b00) && !cent;
	endfunction

	// Length of a month; any code outside the short months counts as 31 days.
	function automatic logic [4:0] cal_month_len(input logic [3:0] month, input logic leap);
		logic [4:0] len;
		if (month == MONTH_FEB) begin
			len = leap ? DAYS_FEB_LEAP : DAYS_FEB;
		end else if ((month == MONTH_APR) || (month == MONTH_JUN) ||
				(month == MONTH_SEP) || (month == MONTH_NOV)) begin
			len = DAYS_SHORT;
		end else begin
			len = DAYS_LONG;
		end
		return len;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/cal_mod400.sv */
// Unit that reduces a year to its value modulo 400 by a shift and a
// reciprocal multiplication followed by one multiply-back and subtract.
// Depends on cal_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cal_mod400 #(
	parameter int unsigned YEAR_BITS = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [YEAR_BITS-1:0]  value,
	output cal_pkg::cal_mod_stat_t     stat
);

	// The year is divided by 16 with a shift, then by 25 with a reciprocal that is
	// rounded up, which gives the exact quotient for every value of the shifted year.
	localparam int unsigned HI_W    = YEAR_BITS - 4;
	localparam int unsigned RECIP_W = HI_W + 1;
	localparam int unsigned PROD_W  = HI_W + RECIP_W;
	localparam int unsigned SHIFT   = HI_W + 5;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << SHIFT) + 64'd24) / 64'd25);

	logic                        mul_pend_q;
	logic                        sub_pend_q;
	logic [YEAR_BITS-1:0]        val_q;
	logic [PROD_W-1:0]           prod_q;
	logic [cal_pkg::REM_W-1:0]   rem_q;
	logic [cal_pkg::REM_W-1:0]   quot_lo;

	// Only the low bits of the quotient matter, since the remainder is below 512.
	assign quot_lo = cal_pkg::REM_W'(prod_q >> SHIFT);

	// Step flags: the multiply step, then the subtract step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_pend_q <= 1'b0;
			sub_pend_q <= 1'b0;
		end else begin
			mul_pend_q <= start;
			sub_pend_q <= mul_pend_q;
		end
	end

	// Working year, product and remainder.
	always_ff @(posedge clk) begin
		if (start) begin
			val_q <= value;
		end
		if (mul_pend_q) begin
			prod_q <= PROD_W'(val_q[YEAR_BITS-1:4]) * PROD_W'(RECIP);
		end
		if (sub_pend_q) begin
			rem_q <= val_q[cal_pkg::REM_W-1:0] -
				cal_pkg::REM_W'(quot_lo * cal_pkg::YEAR_CYCLE);
		end
	end

	assign stat = {mul_pend_q || sub_pend_q, rem_q};

endmodule

`default_nettype wire

/* hw/rtl/cal_day_step.sv */
// Shared day stepping unit: moves a date one day forward or back, with month,
// year and leap handling. Purely combinational. Depends on cal_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cal_day_step #(
	parameter int unsigned YEAR_BITS = 16
) (
	input  wire logic                 back,
	input  cal_pkg::cal_date_t        date,
	input  wire logic [YEAR_BITS-1:0] year,
	output cal_pkg::cal_date_t        date_next,
	output logic [YEAR_BITS-1:0]      year_next
);

	localparam logic [YEAR_BITS-1:0]      YEAR_MAX = {YEAR_BITS{1'b1}};
	// Remainder modulo 400 of the largest year, for wrapping backwards past year 0.
	localparam logic [cal_pkg::REM_W-1:0] MAX_REM  =
		cal_pkg::REM_W'(((64'd1 << YEAR_BITS) - 64'd1) % 64'd400);

	logic       leap;
	logic [4:0] cur_len;
	logic [4:0] prev_len;
	logic [3:0] month_dec;
	logic [5:0] day_inc;
	logic [4:0] month_inc;

	// Month lengths use the current year; stepping back into December never
	// needs the leap flag, so the old year is always the right one.
	always_comb begin
		leap      = cal_pkg::cal_leap(date.rem);
		cur_len   = cal_pkg::cal_month_len(date.month, leap);
		month_dec = date.month - 4'd1;
		prev_len  = cal_pkg::cal_month_len(month_dec, leap);
		day_inc   = {1'b0, date.day} + 6'd1;
		month_inc = {1'b0, date.month} + 5'd1;
	end

	// One step in the chosen direction.
	always_comb begin
		date_next = date;
		year_next = year;
		if (!back) begin
			if (day_inc > {1'b0, cur_len}) begin
				date_next.day = cal_pkg::DAY_FIRST;
				if (month_inc > {1'b0, cal_pkg::MONTH_DEC}) begin
					date_next.month = cal_pkg::MONTH_JAN;
					if (year == YEAR_MAX) begin
						year_next     = '0;
						date_next.rem = '0;
					end else begin
						year_next     = year + YEAR_BITS'(1);
						date_next.rem = (date.rem == cal_pkg::REM_LAST) ?
							'0 : date.rem + cal_pkg::REM_W'(1);
					end
				end else begin
					date_next.month = month_inc[3:0];
				end
			end else begin
				date_next.day = day_inc[4:0];
			end
		end else begin
			if (date.day > cal_pkg::DAY_FIRST) begin
				date_next.day = date.day - 5'd1;
			end else if (date.month > cal_pkg::MONTH_JAN) begin
				date_next.month = month_dec;
				date_next.day   = prev_len;
			end else begin
				date_next.month = cal_pkg::MONTH_DEC;
				date_next.day   = cal_pkg::DAYS_LONG;
				if (year == '0) begin
					year_next     = YEAR_MAX;
					date_next.rem = MAX_REM;
				end else begin
					year_next     = year - YEAR_BITS'(1);
					date_next.rem = (date.rem == '0) ?
						cal_pkg::REM_LAST : date.rem - cal_pkg::REM_W'(1);
				end
			end
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/calendar_date_counter.sv */
// Calendar date counter: a compare or an unused code goes straight to its result beat;
// next/previous day makes one step, and add/subtract of a count makes count steps
// (one day per cycle through the shared step unit); set waits for the modulo-400 unit.
// The block takes one item at a time; the input is ready again as the result is
// loaded into the output register.
// Reset is asynchronous and active low and restores the date 1 January 2000.
`timescale 1ns / 1ps
`default_nettype none

module calendar_date_counter #(
	parameter int unsigned YEAR_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// count[15:0], in_day[20:16], in_month[24:21], in_year[40:25], zero fill [47:41]
	input  wire logic [47:0] s_axis_tdata,
	// op[2:0]
	input  wire logic [2:0]  s_axis_tuser,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// out_day[4:0], out_month[8:5], out_year[24:9], is_greater[25], is_equal[26],
	// is_less[27], zero fill [31:28]
	output logic [31:0]      m_axis_tdata
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_STEP = 4'b0010,
		ST_MOD  = 4'b0100,
		ST_FIN  = 4'b1000
	} state_t;

	state_t                   state_q;
	cal_pkg::cal_date_t       date_q;
	logic [YEAR_BITS-1:0]     year_q;
	logic [15:0]              remain_q;
	logic                     back_q;
	logic [4:0]               cmp_day_q;
	logic [3:0]               cmp_month_q;
	logic [YEAR_BITS-1:0]     cmp_year_q;
	logic                     m_valid_q;
	logic [31:0]              m_data_q;

	cal_pkg::cal_op_t         op;
	logic [15:0]              in_count;
	logic [4:0]               in_day;
	logic [3:0]               in_month;
	logic [YEAR_BITS-1:0]     in_year;
	logic                     in_beat;
	logic                     out_free;
	logic                     mod_start;
	cal_pkg::cal_mod_stat_t   mod_stat;
	cal_pkg::cal_date_t       step_date;
	logic [YEAR_BITS-1:0]     step_year;
	logic                     gt;
	logic                     eq;
	logic                     lt;

	// Unpack the input beat.
	assign op        = cal_pkg::cal_op_t'(s_axis_tuser);
	assign in_count  = s_axis_tdata[15:0];
	assign in_day    = s_axis_tdata[20:16];
	assign in_month  = s_axis_tdata[24:21];
	assign in_year   = YEAR_BITS'(s_axis_tdata[40:25]);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_beat       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_valid_q || m_axis_tready;
	assign mod_start     = in_beat && (op == cal_pkg::OP_SET);

	cal_mod400 #(
		.YEAR_BITS (YEAR_BITS)
	) u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mod_start),
		.value  (in_year),
		.stat   (mod_stat)
	);

	cal_day_step #(
		.YEAR_BITS (YEAR_BITS)
	) u_step (
		.back      (back_q),
		.date      (date_q),
		.year      (year_q),
		.date_next (step_date),
		.year_next (step_year)
	);

	// Compare the stored date with the item's date: year first, then month, then day.
	always_comb begin
		eq = (year_q == cmp_year_q) && (date_q.month == cmp_month_q) &&
			(date_q.day == cmp_day_q);
		if (year_q != cmp_year_q) begin
			gt = year_q > cmp_year_q;
		end else if (date_q.month != cmp_month_q) begin
			gt = date_q.month > cmp_month_q;
		end else begin
			gt = date_q.day > cmp_day_q;
		end
		lt = !gt && !eq;
	end

	// Sequencer and stored date.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			date_q.day   <= cal_pkg::RESET_DAY;
			date_q.month <= cal_pkg::RESET_MONTH;
			date_q.rem   <= cal_pkg::RESET_REM;
			year_q       <= YEAR_BITS'(cal_pkg::RESET_YEAR);
			remain_q     <= '0;
			back_q       <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						unique case (op)
							cal_pkg::OP_NEXT: begin
								remain_q <= 16'd1;
								back_q   <= 1'b0;
								state_q  <= ST_STEP;
							end
							cal_pkg::OP_PREV: begin
								remain_q <= 16'd1;
								back_q   <= 1'b1;
								state_q  <= ST_STEP;
							end
							cal_pkg::OP_ADD: begin
								remain_q <= in_count;
								back_q   <= 1'b0;
								state_q  <= ST_STEP;
							end
							cal_pkg::OP_SUB: begin
								remain_q <= in_count;
								back_q   <= 1'b1;
								state_q  <= ST_STEP;
							end
							cal_pkg::OP_SET: begin
								date_q.day   <= in_day;
								date_q.month <= in_month;
								year_q       <= in_year;
								state_q      <= ST_MOD;
							end
							default: begin
								state_q <= ST_FIN;
							end
						endcase
					end
				end
				ST_STEP: begin
					if (remain_q == '0) begin
						state_q <= ST_FIN;
					end else begin
						date_q   <= step_date;
						year_q   <= step_year;
						remain_q <= remain_q - 16'd1;
					end
				end
				ST_MOD: begin
					if (!mod_stat.busy) begin
						date_q.rem <= mod_stat.rem;
						state_q    <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result valid flag: set when an item finishes, cleared when the beat is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if ((state_q == ST_FIN) && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// Comparison date of the item, held for the final compare.
	always_ff @(posedge clk) begin
		if (in_beat) begin
			cmp_day_q   <= in_day;
			cmp_month_q <= in_month;
			cmp_year_q  <= in_year;
		end
	end

	// Output register: loaded when the item finishes and the slot is free.
	always_ff @(posedge clk) begin
		if ((state_q == ST_FIN) && out_free) begin
			m_data_q <= {4'b0000, lt, eq, gt, 16'(year_q), date_q.month, date_q.day};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

endmodule

`default_nettype wire

/* hw/rtl/cal_checker.sv */
// Port-level checker for the calendar date counter, with its bind statement.
// Depends on cal_pkg and on the calendar_date_counter top level.
`timescale 1ns / 1ps
`default_nettype none

module cal_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic [47:0] s_axis_tdata,
	input wire logic [2:0]  s_axis_tuser,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [31:0] m_axis_tdata
);

	// Exactly one of greater, equal and less is reported.
	a_flags_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> $onehot(m_axis_tdata[27:25]))
		else $error("comparison flags are not one-hot");

	// A stalled result beat keeps its data.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("result beat changed while stalled");

	// The block works on one item at a time.
	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("input accepted while an item is in progress");

	// A compare accepted while no result beat is waiting goes through the finish state to a valid result.
	a_compare_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && !m_axis_tvalid &&
			(s_axis_tuser == cal_pkg::OP_COMPARE)) |=> ##1 m_axis_tvalid)
		else $error("compare result not delivered in time");

endmodule

bind calendar_date_counter cal_checker u_cal_checker (.*);

`default_nettype wire
